// File: rtl/itd_pkg.sv
// Package for the integer to decimal text converter.
// Holds the transfer payload types, ASCII constants, control state codes
// and the per-cycle operation struct sent to the digit cells. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itd_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int INPUT_WIDTH     = 64;
    localparam int CHAR_WIDTH      = 7;
    localparam int DIGIT_WIDTH     = 4;

    localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_WIDTH-1:0]  CHAR_MINUS = 7'd45;
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_ADJ_ADD = 4'd3;
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_MAX     = 4'd9;

    typedef struct packed {
        logic                   operation;
        logic [INPUT_WIDTH-1:0] value;
    } num_t;

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] character;
        logic                  last;
    } txt_t;

    // One operation for the whole chain of digit cells in a given cycle.
    typedef struct packed {
        logic clear;
        logic dabble;
        logic advance;
    } cell_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: rtl/itd_digit_cell.sv
// One BCD digit cell of the shift-and-add-3 conversion chain.
// Depends on itd_pkg for the cell operation struct and digit constants.
`timescale 1ns / 1ps
`default_nettype none

module itd_digit_cell
    import itd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cell_op_t               op,
    input  wire logic                   bit_in,
    input  wire logic [DIGIT_WIDTH-1:0] digit_in,
    output logic                        bit_out,
    output logic [DIGIT_WIDTH-1:0]      digit
);

    logic [DIGIT_WIDTH-1:0] digit_reg;
    logic [DIGIT_WIDTH-1:0] digit_next;
    logic [DIGIT_WIDTH-1:0] adjusted;

    // A digit of five or more would pass nine after doubling, so add three first.
    assign adjusted = (digit_reg >= DIGIT_ADJ_MIN) ? (digit_reg + DIGIT_ADJ_ADD) : digit_reg;
    assign bit_out  = adjusted[DIGIT_WIDTH-1];
    assign digit    = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (op.clear)
        begin
            digit_next = '0;
        end
        else if (op.dabble)
        begin
            digit_next = {adjusted[DIGIT_WIDTH-2:0], bit_in};
        end
        else if (op.advance)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/integer_to_decimal_text_top.sv
// Top level of the integer to decimal text converter: control, magnitude
// shift register, output register and the chain of itd_digit_cell instances.
// Depends on itd_pkg and itd_digit_cell.
//
//  Channel  Dir  Handshake              Payload
//  num      in   num_valid/num_ready    num_data  (operation, value)
//  txt      out  txt_valid/txt_ready    txt_data  (character, last)
//
// A number is taken only when the converter is idle. Conversion shifts one
// magnitude bit per cycle through the digit cell chain. Leading zero digits
// then leave the chain at one per cycle, and the text follows: a minus sign
// for a negative number, then the digits, each character held while the
// output is stalled. The idle state then takes the next number. Reset clears
// the control state and the digit cells; a stalled output simply holds the
// chain.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_decimal_text_top
    import itd_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic num_valid,
    output logic      num_ready,
    input  wire num_t num_data,
    output logic      txt_valid,
    input  wire logic txt_ready,
    output txt_t      txt_data
);

    // Decimal digits of 2^VALUE_WIDTH - 1; 1233/4096 approximates log10(2).
    localparam int NDIG    = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int CNT_W   = $clog2(VALUE_WIDTH);
    localparam int REM_W   = $clog2(NDIG + 1);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(VALUE_WIDTH - 1);
    localparam logic [REM_W-1:0] REM_FULL = REM_W'(NDIG);
    localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

    state_t                 state_reg;
    state_t                 state_next;
    logic [CNT_W-1:0]       bit_cnt_reg;
    logic [CNT_W-1:0]       bit_cnt_next;
    logic [REM_W-1:0]       rem_reg;
    logic [REM_W-1:0]       rem_next;
    logic                   neg_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic                   txt_valid_reg;
    logic                   txt_valid_next;
    txt_t                   txt_reg;

    logic                   take;
    logic                   out_free;
    logic                   skip_zero;
    logic                   emit_sign;
    logic                   emit_digit;
    logic                   value_neg;
    logic [VALUE_WIDTH-1:0] value_raw;
    cell_op_t               cell_op;

    logic [NDIG:0]          bit_link;
    logic [DIGIT_WIDTH-1:0] digit_chain [NDIG+1];
    logic [DIGIT_WIDTH-1:0] top_digit;

    assign value_raw = num_data.value[VALUE_WIDTH-1:0];
    assign value_neg = num_data.operation && value_raw[VALUE_WIDTH-1];
    assign take      = num_valid && num_ready;
    assign out_free  = !txt_valid_reg || txt_ready;
    assign top_digit = digit_chain[NDIG];
    assign skip_zero = (top_digit == '0) && (rem_reg > REM_ONE);

    // The chain's low end takes the magnitude's top bit while converting and
    // zero digits while the text is shifted out of the high end.
    assign bit_link[0]    = mag_reg[VALUE_WIDTH-1];
    assign digit_chain[0] = '0;

    for (genvar i = 0; i < NDIG; i++)
    begin : g_cell
        itd_digit_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .op       (cell_op),
            .bit_in   (bit_link[i]),
            .digit_in (digit_chain[i]),
            .bit_out  (bit_link[i+1]),
            .digit    (digit_chain[i+1])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (bit_cnt_reg == LAST_BIT)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (!skip_zero)
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && (rem_reg == REM_ONE))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        num_ready      = 1'b0;
        emit_sign      = 1'b0;
        emit_digit     = 1'b0;
        cell_op        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                num_ready     = 1'b1;
                cell_op.clear = num_valid;
            end
            ST_CONV:
            begin
                cell_op.dabble = 1'b1;
            end
            ST_SKIP:
            begin
                cell_op.advance = skip_zero;
            end
            ST_SIGN:
            begin
                emit_sign = out_free;
            end
            ST_EMIT:
            begin
                emit_digit      = out_free;
                cell_op.advance = out_free;
            end
            default:
            begin
                num_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        bit_cnt_next = bit_cnt_reg;
        rem_next     = rem_reg;
        if (take)
        begin
            bit_cnt_next = '0;
            rem_next     = REM_FULL;
        end
        else
        begin
            if (state_reg == ST_CONV)
            begin
                bit_cnt_next = bit_cnt_reg + 1'b1;
            end
            if (cell_op.advance)
            begin
                rem_next = rem_reg - 1'b1;
            end
        end

        if (emit_sign || emit_digit)
        begin
            txt_valid_next = 1'b1;
        end
        else if (txt_ready)
        begin
            txt_valid_next = 1'b0;
        end
        else
        begin
            txt_valid_next = txt_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            rem_reg       <= '0;
            txt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            rem_reg       <= rem_next;
            txt_valid_reg <= txt_valid_next;
        end
    end

    // Two's complement negation in VALUE_WIDTH bits also gives the right
    // magnitude for the most negative value when read as unsigned.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            neg_reg <= value_neg;
            mag_reg <= value_neg ? (~value_raw + 1'b1) : value_raw;
        end
        else if (state_reg == ST_CONV)
        begin
            mag_reg <= {mag_reg[VALUE_WIDTH-2:0], 1'b0};
        end

        if (emit_sign)
        begin
            txt_reg.character <= CHAR_MINUS;
            txt_reg.last      <= 1'b0;
        end
        else if (emit_digit)
        begin
            txt_reg.character <= CHAR_ZERO + {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, top_digit};
            txt_reg.last      <= (rem_reg == REM_ONE);
        end
    end

    assign txt_valid = txt_valid_reg;
    assign txt_data  = txt_reg;

`ifndef SYNTH
    a_no_chain_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |-> !bit_link[NDIG])
        else $error("digit chain overflowed during conversion");

    a_digit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        emit_digit |-> (top_digit <= DIGIT_MAX))
        else $error("emitted digit is not a decimal digit");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SKIP) || (state_reg == ST_SIGN) || (state_reg == ST_EMIT))
        |-> (rem_reg != '0))
        else $error("digit count ran out before the last character");

    a_sign_only_negative: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN) |-> neg_reg)
        else $error("minus sign issued for a non-negative number");

    a_take_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (state_reg == ST_CONV) && (bit_cnt_reg == '0))
        else $error("accepted number did not start conversion");
`endif

endmodule

`default_nettype wire
